>>> sv/rfp_pkg.sv
package rfp_pkg;

	// allow-list geometry
	localparam int TagSlots     = 4;
	localparam int TableEntries = 4;
	localparam int TagWidth     = 40;

	// reader framing bytes
	localparam logic [7:0] ByteStx = 8'h02;
	localparam logic [7:0] ByteEtx = 8'h03;
	localparam logic [7:0] ByteCr  = 8'h0D;
	localparam logic [7:0] ByteLf  = 8'h0A;

	// digits per frame
	localparam logic [3:0] TagDigits    = 4'd10;
	localparam logic [2:0] LastPairIdx  = 3'd5;

	// register indexes
	localparam logic [2:0] RegTagA      = 3'd0;
	localparam logic [2:0] RegTagB      = 3'd1;
	localparam logic [2:0] RegTagC      = 3'd2;
	localparam logic [2:0] RegTagD      = 3'd3;
	localparam logic [2:0] RegTagsInUse = 3'd4;

	// reset contents of the allow-list
	localparam logic [TagWidth-1:0] TagResetA = 40'h0100C1A6B3;
	localparam logic [TagWidth-1:0] TagResetB = 40'h0100C216B5;
	localparam logic [TagWidth-1:0] TagResetC = 40'h0100C201E5;
	localparam logic [TagWidth-1:0] TagResetD = 40'h0100C20086;
	localparam logic [2:0]          TagsInUseReset = 3'd4;

	typedef logic [TagSlots-1:0][TagWidth-1:0] tag_table_t;

	typedef struct packed {
		logic [2:0] match_number;
		logic       authorized;
	} match_t;

	typedef struct packed {
		logic [7:0] value;
		logic       is_hex;
	} digit_t;

	// ascii hex digit to nibble; other characters pass through raw
	function automatic digit_t decode_digit(input logic [7:0] b);
		digit_t d;
		if (b >= 8'h30 && b <= 8'h39) begin
			d.value  = b - 8'h30;
			d.is_hex = 1'b1;
		end else if (b >= 8'h41 && b <= 8'h46) begin
			d.value  = b - 8'h37;
			d.is_hex = 1'b1;
		end else begin
			d.value  = b;
			d.is_hex = 1'b0;
		end
		return d;
	endfunction

endpackage

>>> sv/rfp_tag_match.sv
module rfp_tag_match import rfp_pkg::*; (
	input  logic [TagWidth-1:0] tag,
	input  logic                digits_hex,
	input  tag_table_t          entries,
	input  logic [2:0]          tags_in_use,
	output match_t              match
);

	// parallel compare, lowest entry wins
	always_comb begin
		match = '0;
		for (int i = TableEntries - 1; i >= 0; i--) begin
			if (digits_hex && 3'(i) < tags_in_use && tag == entries[i]) begin
				match.match_number = 3'(i + 1);
				match.authorized   = 1'b1;
			end
		end
	end

endmodule

>>> sv/rfid_frame_parse_match.sv
// Frame parser and allow-list matcher for an ASCII proximity-card reader.
// Reader bytes enter on the rx channel, one word per cycle at full rate: a
// byte is registered, then decoded against the frame state, and a finished
// frame is written to the result register as its last byte is decoded.
// Outside a frame only STX (0x02) matters; inside, CR, LF, ETX or STX
// drop the frame silently. Twelve further characters form a frame: ten tag
// digits and two checksum digits, packed in pairs. Each complete frame gives
// one result word with the 40-bit tag, the received checksum, the XOR check,
// and the first allow-list entry (of tags_in_use) it matches; a match needs
// all ten tag digits to be uppercase hex and ignores the checksum. The rx
// side stalls only while a result is held by a stalled result channel.
// Registers (cfg_index): 0..3 allow-list entries, 4 tags_in_use; other
// indexes are ignored. cfg_ready is always high.
module rfid_frame_parse_match import rfp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// reader bytes
	input  logic                rx_valid,
	output logic                rx_stall,
	input  logic [7:0]          rx_byte,
	// configuration writes
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [TagWidth-1:0] cfg_data,
	// frame results
	output logic                result_valid,
	input  logic                result_stall,
	output logic [TagWidth-1:0] tag_value,
	output logic [7:0]          received_checksum,
	output logic                checksum_ok,
	output logic [2:0]          match_number,
	output logic                authorized
);

	tag_table_t          tag_entry_q;
	logic [2:0]          tags_in_use_q;

	logic                valid_s1;
	logic [7:0]          byte_s1;

	logic                in_frame_q;
	logic [3:0]          digit_count_q;
	logic [7:0]          high_digit_q;
	logic [TagWidth-1:0] packed_q;
	logic [7:0]          xor_q;
	logic                all_hex_q;

	logic                advance;
	logic                is_abort;
	digit_t              dig;
	logic [7:0]          pair_byte;
	logic                last_pair;
	logic                emit;
	match_t              match;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_entry_q[0] <= TagResetA;
			tag_entry_q[1] <= TagResetB;
			tag_entry_q[2] <= TagResetC;
			tag_entry_q[3] <= TagResetD;
			tags_in_use_q  <= TagsInUseReset;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				RegTagA:      tag_entry_q[0] <= cfg_data;
				RegTagB:      tag_entry_q[1] <= cfg_data;
				RegTagC:      tag_entry_q[2] <= cfg_data;
				RegTagD:      tag_entry_q[3] <= cfg_data;
				RegTagsInUse: tags_in_use_q  <= cfg_data[2:0];
				default:      ;
			endcase
		end
	end

	// stage 1 moves on unless a result is held up downstream
	assign advance  = !(result_valid && result_stall);
	assign rx_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byte_s1  <= '0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
			byte_s1  <= rx_byte;
		end
	end

	// per-byte decode
	assign is_abort  = byte_s1 == ByteCr || byte_s1 == ByteLf ||
	                   byte_s1 == ByteEtx || byte_s1 == ByteStx;
	assign dig       = decode_digit(byte_s1);
	assign pair_byte = dig.value | {high_digit_q[3:0], 4'h0};
	assign last_pair = digit_count_q[3:1] == LastPairIdx;
	assign emit      = valid_s1 && advance && in_frame_q && !is_abort &&
	                   digit_count_q[0] && last_pair;

	rfp_tag_match u_match (
		.tag         (packed_q),
		.digits_hex  (all_hex_q),
		.entries     (tag_entry_q),
		.tags_in_use (tags_in_use_q),
		.match       (match)
	);

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q    <= 1'b0;
			digit_count_q <= '0;
			high_digit_q  <= '0;
			packed_q      <= '0;
			xor_q         <= '0;
			all_hex_q     <= 1'b1;
		end else if (valid_s1 && advance) begin
			if (!in_frame_q) begin
				if (byte_s1 == ByteStx) begin
					in_frame_q    <= 1'b1;
					digit_count_q <= '0;
					high_digit_q  <= '0;
					packed_q      <= '0;
					xor_q         <= '0;
					all_hex_q     <= 1'b1;
				end
			end else if (is_abort) begin
				in_frame_q <= 1'b0;
			end else begin
				if (digit_count_q < TagDigits && !dig.is_hex) begin
					all_hex_q <= 1'b0;
				end
				if (digit_count_q[0]) begin
					if (last_pair) begin
						in_frame_q    <= 1'b0;
						digit_count_q <= '0;
					end else begin
						packed_q      <= {packed_q[TagWidth-9:0], pair_byte};
						xor_q         <= xor_q ^ pair_byte;
						digit_count_q <= digit_count_q + 4'd1;
					end
				end else begin
					high_digit_q  <= dig.value;
					digit_count_q <= digit_count_q + 4'd1;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (emit) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (emit) begin
			tag_value         <= packed_q;
			received_checksum <= pair_byte;
			checksum_ok       <= pair_byte == xor_q;
			match_number      <= match.match_number;
			authorized        <= match.authorized;
		end
	end

endmodule
